// ===== src/scl_pkg.sv =====
// Package for the scan code line assembler: key codes, result kinds and keymap tables.
`default_nettype none

package scl_pkg;

    // Line geometry
    localparam int LINE_LENGTH = 80;
    localparam int POS_W       = 7;
    localparam int CHAR_W      = 7;

    // Set-1 scan codes with special handling
    localparam logic [7:0] KEY_BACKSPACE = 8'd14;
    localparam logic [7:0] KEY_ENTER     = 8'd28;
    localparam logic [7:0] KEY_CAPS      = 8'd58;
    localparam logic [7:0] KEY_LSHIFT    = 8'd42;
    localparam logic [7:0] KEY_RSHIFT    = 8'd54;
    localparam logic [7:0] KEY_LSHIFT_UP = 8'd170;
    localparam logic [7:0] KEY_RSHIFT_UP = 8'd182;

    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 7'h7a;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_CHAR  = 2'd0,
        KIND_ERASE = 2'd1,
        KIND_ENTER = 2'd2
    } t_kind;

    // Unshifted keymap; zero means no character
    function automatic logic [CHAR_W-1:0] plain_char(input logic [6:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'd2:    ch = 7'h31; // 1
            7'd3:    ch = 7'h32;
            7'd4:    ch = 7'h33;
            7'd5:    ch = 7'h34;
            7'd6:    ch = 7'h35;
            7'd7:    ch = 7'h36;
            7'd8:    ch = 7'h37;
            7'd9:    ch = 7'h38;
            7'd10:   ch = 7'h39;
            7'd11:   ch = 7'h30; // 0
            7'd12:   ch = 7'h2d; // -
            7'd13:   ch = 7'h3d; // =
            7'd15:   ch = 7'h09; // tab
            7'd16:   ch = 7'h71; // q
            7'd17:   ch = 7'h77;
            7'd18:   ch = 7'h65;
            7'd19:   ch = 7'h72;
            7'd20:   ch = 7'h74;
            7'd21:   ch = 7'h79;
            7'd22:   ch = 7'h75;
            7'd23:   ch = 7'h69;
            7'd24:   ch = 7'h6f;
            7'd25:   ch = 7'h70; // p
            7'd27:   ch = 7'h5b; // [
            7'd30:   ch = 7'h61; // a
            7'd31:   ch = 7'h73;
            7'd32:   ch = 7'h64;
            7'd33:   ch = 7'h66;
            7'd34:   ch = 7'h67;
            7'd35:   ch = 7'h68;
            7'd36:   ch = 7'h6a;
            7'd37:   ch = 7'h6b;
            7'd38:   ch = 7'h6c; // l
            7'd40:   ch = 7'h7e; // ~
            7'd41:   ch = 7'h27; // '
            7'd43:   ch = 7'h5d; // ]
            7'd44:   ch = 7'h7a; // z
            7'd45:   ch = 7'h78;
            7'd46:   ch = 7'h63;
            7'd47:   ch = 7'h76;
            7'd48:   ch = 7'h62;
            7'd49:   ch = 7'h6e;
            7'd50:   ch = 7'h6d; // m
            7'd51:   ch = 7'h2c; // ,
            7'd52:   ch = 7'h2e; // .
            7'd53:   ch = 7'h3b; // ;
            7'd55:   ch = 7'h2a; // *
            7'd57:   ch = 7'h20; // space
            7'd78:   ch = 7'h2b; // +
            7'd86:   ch = 7'h5c; // backslash
            7'd115:  ch = 7'h2f; // /
            default: ch = '0;
        endcase
        return ch;
    endfunction

    // Shifted keymap
    function automatic logic [CHAR_W-1:0] shift_char(input logic [6:0] code);
        logic [CHAR_W-1:0] ch;
        unique case (code)
            7'd2:    ch = 7'h21; // !
            7'd3:    ch = 7'h40; // @
            7'd4:    ch = 7'h23; // #
            7'd5:    ch = 7'h24; // $
            7'd6:    ch = 7'h25; // %
            7'd7:    ch = 7'h36; // 6 (dead key on this layout)
            7'd8:    ch = 7'h26; // &
            7'd9:    ch = 7'h2a; // *
            7'd10:   ch = 7'h28; // (
            7'd11:   ch = 7'h29; // )
            7'd12:   ch = 7'h5f; // _
            7'd13:   ch = 7'h2b; // +
            7'd15:   ch = 7'h09;
            7'd16:   ch = 7'h51; // Q
            7'd17:   ch = 7'h57;
            7'd18:   ch = 7'h45;
            7'd19:   ch = 7'h52;
            7'd20:   ch = 7'h54;
            7'd21:   ch = 7'h59;
            7'd22:   ch = 7'h55;
            7'd23:   ch = 7'h49;
            7'd24:   ch = 7'h4f;
            7'd25:   ch = 7'h50;
            7'd27:   ch = 7'h7b; // {
            7'd30:   ch = 7'h41; // A
            7'd31:   ch = 7'h53;
            7'd32:   ch = 7'h44;
            7'd33:   ch = 7'h46;
            7'd34:   ch = 7'h47;
            7'd35:   ch = 7'h48;
            7'd36:   ch = 7'h4a;
            7'd37:   ch = 7'h4b;
            7'd38:   ch = 7'h4c;
            7'd40:   ch = 7'h5e; // ^
            7'd41:   ch = 7'h22; // "
            7'd43:   ch = 7'h7d; // }
            7'd44:   ch = 7'h5a; // Z
            7'd45:   ch = 7'h58;
            7'd46:   ch = 7'h43;
            7'd47:   ch = 7'h56;
            7'd48:   ch = 7'h42;
            7'd49:   ch = 7'h4e;
            7'd50:   ch = 7'h4d;
            7'd51:   ch = 7'h3c; // <
            7'd52:   ch = 7'h3e; // >
            7'd53:   ch = 7'h3a; // :
            7'd55:   ch = 7'h2a;
            7'd57:   ch = 7'h20;
            7'd78:   ch = 7'h2b;
            7'd86:   ch = 7'h7c; // |
            7'd115:  ch = 7'h3f; // ?
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// ===== src/scl_in_if.sv =====
// Stream interface carrying scan code beats into the assembler.
`default_nettype none

interface scl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

`default_nettype wire

// ===== src/scl_out_if.sv =====
// Stream interface carrying line result beats out of the assembler.
`default_nettype none

interface scl_out_if
    import scl_pkg::*;
;
    logic              valid;
    logic              ready;
    t_kind             kind;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] char_code;
    logic              line_end;

    modport source (output valid, output kind, output position, output char_code,
                    output line_end, input ready);
    modport sink   (input valid, input kind, input position, input char_code,
                    input line_end, output ready);
endinterface

`default_nettype wire

// ===== src/scancode_line_assembler.sv =====
// Scan code line assembler: keymap lookup, shift/caps tracking and line position.
//
//  channel  | dir | payload                                  | beats
//  ---------+-----+------------------------------------------+--------------------
//  i_in     | in  | scan_code[7:0]                           | one per key event
//  o_out    | out | kind, position[6:0], char_code, line_end | zero or one per in
//
//  One scan code beat is taken every cycle unless a stalled result blocks it;
//  its result appears in the next cycle from the output register. The rate is
//  set by the single keymap lookup and position update between the input
//  handshake and the result register. Reset (synchronous, active low) clears
//  shift, caps lock, position and the output valid. A stalled output holds its
//  beat; a new input is taken in the same cycle the held beat leaves.
`default_nettype none

module scancode_line_assembler
    import scl_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    scl_in_if.sink      i_in,
    scl_out_if.source   o_out
);

    localparam logic [POS_W:0] LAST_POS = (POS_W + 1)'(LINE_LENGTH - 1);

    logic              r_shift, n_shift;
    logic              r_caps, n_caps;
    logic [POS_W-1:0]  r_pos, n_pos;

    logic              r_valid;
    t_kind             r_kind;
    logic [POS_W-1:0]  r_position;
    logic [CHAR_W-1:0] r_char;
    logic              r_line_end;

    logic              w_accept;
    logic              w_res_valid;
    t_kind             w_kind;
    logic [POS_W-1:0]  w_position;
    logic [CHAR_W-1:0] w_char;
    logic              w_line_end;
    logic [CHAR_W-1:0] w_plain;
    logic [CHAR_W-1:0] w_shifted;
    logic              w_letter;
    logic              w_upper;
    logic [7:0]        w_code;

    // Handshake: output register frees up as soon as it is taken
    assign i_in.ready = !r_valid || o_out.ready;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_code     = i_in.scan_code;

    // Keymap lookup and case choice
    assign w_plain   = plain_char(w_code[6:0]);
    assign w_shifted = shift_char(w_code[6:0]);
    assign w_letter  = (w_plain >= ASCII_LOWER_A) && (w_plain <= ASCII_LOWER_Z);
    assign w_upper   = w_letter ? (r_caps ^ r_shift) : r_shift;

    // Key decode, next state and result
    always_comb begin
        n_shift     = r_shift;
        n_caps      = r_caps;
        n_pos       = r_pos;
        w_res_valid = 1'b0;
        w_kind      = KIND_CHAR;
        w_position  = r_pos;
        w_char      = '0;
        w_line_end  = 1'b0;
        priority if (w_code == KEY_LSHIFT || w_code == KEY_RSHIFT) begin
            n_shift = 1'b1;
        end else if (w_code == KEY_LSHIFT_UP || w_code == KEY_RSHIFT_UP) begin
            n_shift = 1'b0;
        end else if (w_code == KEY_CAPS) begin
            n_caps = !r_caps;
        end else if (w_code == KEY_BACKSPACE) begin
            if (r_pos != '0) begin
                n_pos       = r_pos - POS_W'(1);
                w_res_valid = 1'b1;
                w_kind      = KIND_ERASE;
                w_position  = r_pos - POS_W'(1);
            end
        end else if (w_code == KEY_ENTER) begin
            n_pos       = '0;
            w_res_valid = 1'b1;
            w_kind      = KIND_ENTER;
            w_line_end  = 1'b1;
        end else if (!w_code[7] && w_plain != '0) begin
            w_res_valid = 1'b1;
            w_char      = w_upper ? w_shifted : w_plain;
            // line full once the last slot is written
            if ({1'b0, r_pos} >= LAST_POS) begin
                n_pos      = '0;
                w_line_end = 1'b1;
            end else begin
                n_pos = r_pos + POS_W'(1);
            end
        end else begin
            // release or unmapped code: nothing to do
            n_pos = r_pos;
        end
    end

    // Key state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
            r_pos   <= '0;
        end else if (w_accept) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
            r_pos   <= n_pos;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= w_res_valid;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_accept && w_res_valid) begin
            r_kind     <= w_kind;
            r_position <= w_position;
            r_char     <= w_char;
            r_line_end <= w_line_end;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.kind      = r_kind;
    assign o_out.position  = r_position;
    assign o_out.char_code = r_char;
    assign o_out.line_end  = r_line_end;

endmodule

`default_nettype wire

// ===== verif/tb_scancode_line_assembler.sv =====
// Testbench for the scan code line assembler: predictor, beat driver and result checker.
`timescale 1ns / 100ps

module tb_scancode_line_assembler;
    import scl_pkg::*;

    localparam int MAX_CYCLES      = 200_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 10;

    typedef struct packed {
        t_kind             kind;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] char_code;
        logic              line_end;
    } t_line_beat;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Testbench-side drive registers, known from time zero
    logic       drv_valid = 1'b0;
    logic [7:0] drv_code  = '0;
    logic       drv_ready = 1'b0;

    scl_in_if  in_if ();
    scl_out_if out_if ();

    assign in_if.valid     = drv_valid;
    assign in_if.scan_code = drv_code;
    assign out_if.ready    = drv_ready;

    scancode_line_assembler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Keymap of the predictor, filled at time zero
    logic [CHAR_W-1:0] lower_key [128];
    logic [CHAR_W-1:0] upper_key [128];

    // Predicted keyboard and line state
    logic             shift_held = 1'b0;
    logic             caps_on    = 1'b0;
    logic [POS_W-1:0] line_pos   = '0;

    logic [7:0] stim_q[$];
    t_line_beat line_beats_due[$];

    int next_code      = 0;
    int beats_seen     = 0;
    int accepted_codes = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    int chars_stored   = 0;
    int erases         = 0;
    int enter_lines    = 0;
    int full_lines     = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic map_keys(input int first, input string plain, input string shifted);
        byte b;
        for (int i = 0; i < plain.len(); i++) begin
            b = plain[i];
            lower_key[first + i] = b[6:0];
            b = shifted[i];
            upper_key[first + i] = b[6:0];
        end
    endtask

    // Expected result of one scan code; updates the predicted state
    function automatic bit predict_key(input logic [7:0] code, output t_line_beat beat);
        logic [CHAR_W-1:0] ch;
        logic              upper;
        beat = '0;
        if (code == KEY_LSHIFT || code == KEY_RSHIFT) begin
            shift_held = 1'b1;
            return 1'b0;
        end
        if (code == KEY_LSHIFT_UP || code == KEY_RSHIFT_UP) begin
            shift_held = 1'b0;
            return 1'b0;
        end
        if (code == KEY_CAPS) begin
            caps_on = ~caps_on;
            return 1'b0;
        end
        if (code == KEY_BACKSPACE) begin
            if (line_pos == '0)
                return 1'b0;
            line_pos      = line_pos - POS_W'(1);
            beat.kind     = KIND_ERASE;
            beat.position = line_pos;
            return 1'b1;
        end
        if (code == KEY_ENTER) begin
            beat.kind     = KIND_ENTER;
            beat.position = line_pos;
            beat.line_end = 1'b1;
            line_pos      = '0;
            return 1'b1;
        end
        if (code[7] || lower_key[code[6:0]] == '0)
            return 1'b0;

        // Letters follow caps XOR shift, everything else shift alone
        ch = lower_key[code[6:0]];
        if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z)
            upper = caps_on ^ shift_held;
        else
            upper = shift_held;
        if (upper)
            ch = upper_key[code[6:0]];

        beat.kind      = KIND_CHAR;
        beat.position  = line_pos;
        beat.char_code = ch;
        if (int'(line_pos) + 1 >= LINE_LENGTH) begin
            beat.line_end = 1'b1;
            line_pos      = '0;
        end else begin
            line_pos = line_pos + POS_W'(1);
        end
        return 1'b1;
    endfunction

    // Sender: offers queued codes, holds a beat until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!(drv_valid && accepted_codes == beats_seen)) begin
            beats_seen = accepted_codes;
            if (next_code < stim_q.size() && $urandom_range(99) >= sender_idle_pct) begin
                drv_code  <= stim_q[next_code];
                drv_valid <= 1'b1;
                next_code++;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            drv_ready <= 1'b0;
        end else begin
            drv_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Monitor: check result beats, then predict from accepted code beats
    always @(posedge i_clk) begin
        t_line_beat got;
        t_line_beat want;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                got = {out_if.kind, out_if.position, out_if.char_code, out_if.line_end};
                if (line_beats_due.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result kind=%0d pos=%0d char=%02h end=%0b",
                             $time, got.kind, got.position, got.char_code, got.line_end);
                end else begin
                    want = line_beats_due.pop_front();
                    if (got.kind !== want.kind || got.position !== want.position ||
                        got.char_code !== want.char_code || got.line_end !== want.line_end) begin
                        error_count++;
                        $display("%0t: mismatch expected kind=%0d pos=%0d char=%02h end=%0b",
                                 $time, want.kind, want.position, want.char_code,
                                 want.line_end);
                        $display("%0t:          actual   kind=%0d pos=%0d char=%02h end=%0b",
                                 $time, got.kind, got.position, got.char_code, got.line_end);
                    end
                    case (want.kind)
                        KIND_CHAR:  chars_stored++;
                        KIND_ERASE: erases++;
                        default:    enter_lines++;
                    endcase
                    if (want.kind == KIND_CHAR && want.line_end)
                        full_lines++;
                end
            end
            if (in_if.valid && in_if.ready) begin
                accepted_codes++;
                if (predict_key(in_if.scan_code, want))
                    line_beats_due.push_back(want);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, line_beats_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // Sender pause: all codes taken and every result back
    task automatic wait_drained();
        while (accepted_codes != stim_q.size() || line_beats_due.size() != 0)
            @(negedge i_clk);
    endtask

    // Typing-like random codes: mostly keys, some editing, modifiers and noise
    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        int         pick;
        logic [7:0] code;
        @(posedge i_clk);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                do code = 8'($urandom_range(127));
                while (lower_key[code[6:0]] == '0);
            end else if (pick < 76) begin
                code = KEY_BACKSPACE;
            end else if (pick < 78) begin
                code = KEY_ENTER;
            end else if (pick < 82) begin
                code = $urandom_range(1) ? KEY_LSHIFT : KEY_RSHIFT;
            end else if (pick < 86) begin
                code = $urandom_range(1) ? KEY_LSHIFT_UP : KEY_RSHIFT_UP;
            end else if (pick < 89) begin
                code = KEY_CAPS;
            end else begin
                code = 8'($urandom_range(255));
            end
            stim_q.push_back(code);
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < 128; i++) begin
            lower_key[i] = '0;
            upper_key[i] = '0;
        end
        map_keys(2,   "1234567890-=", "!@#$%6&*()_+");
        map_keys(16,  "qwertyuiop",   "QWERTYUIOP");
        map_keys(27,  "[",            "{");
        map_keys(30,  "asdfghjkl",    "ASDFGHJKL");
        map_keys(40,  "~'",           "^\"");
        map_keys(43,  "]zxcvbnm,.;",  "}ZXCVBNM<>:");
        map_keys(55,  "*",            "*");
        map_keys(57,  " ",            " ");
        map_keys(78,  "+",            "+");
        map_keys(86,  "\\",           "|");
        map_keys(115, "/",            "?");
        lower_key[15] = 7'h09;
        upper_key[15] = 7'h09;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, erase on an empty line, enter on an empty line,
        // caps and shift combinations, shifted symbols, tab, plain releases
        @(posedge i_clk);
        stim_q.push_back(8'h00);
        stim_q.push_back(KEY_BACKSPACE);
        stim_q.push_back(KEY_ENTER);
        stim_q.push_back(8'd30);
        stim_q.push_back(KEY_CAPS);
        stim_q.push_back(8'd30);
        stim_q.push_back(KEY_LSHIFT);
        stim_q.push_back(8'd30);
        stim_q.push_back(8'd2);
        stim_q.push_back(KEY_LSHIFT_UP);
        stim_q.push_back(KEY_CAPS);
        stim_q.push_back(KEY_RSHIFT);
        stim_q.push_back(8'd115);
        stim_q.push_back(KEY_RSHIFT_UP);
        stim_q.push_back(8'd15);
        stim_q.push_back(8'd86);
        stim_q.push_back(8'h9e);
        stim_q.push_back(8'hff);
        stim_q.push_back(8'h80);
        stim_q.push_back(8'h7f);
        stim_q.push_back(KEY_BACKSPACE);
        stim_q.push_back(8'd44);
        stim_q.push_back(KEY_ENTER);
        wait_drained();

        // A full line with no enter, then one character on the next line
        @(posedge i_clk);
        for (int n = 0; n <= LINE_LENGTH; n++)
            stim_q.push_back(8'd45);
        wait_drained();

        run_phase(0,  0,  280);
        run_phase(88, 0,  280);
        run_phase(0,  88, 280);

        // Long receiver hold-off while codes keep coming
        @(posedge i_clk);
        hold_requests++;
        run_phase(22, 22, 300);

        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Run: %0d scan codes in %0d cycles, idle/stall phases and a %0d-cycle hold-off",
                 accepted_codes, cycle_count, HOLD_OFF_CYCLES);
        $display("Results: %0d characters, %0d erases, %0d enter lines, %0d full lines",
                 chars_stored, erases, enter_lines, full_lines);
        if (error_count == 0 && line_beats_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/scl_pkg.sv
src/scl_in_if.sv
src/scl_out_if.sv
src/scancode_line_assembler.sv
verif/tb_scancode_line_assembler.sv
